// ===== hdl/scpa_pkg.sv =====
// scpa_pkg: shared types, command and status codes for the size-class pool allocator
// depends on nothing; imported by the top level
`default_nettype none

package scpa_pkg;

    localparam int unsigned UNIT_W     = 14;
    localparam int unsigned LINK_DEPTH = 16384;
    localparam int unsigned SIZE_W     = 9;
    localparam int unsigned UNITS_W    = 7;

    localparam int unsigned DEF_BLOCK_BYTES    = 8192;
    localparam int unsigned DEF_MAX_ATOM_BYTES = 256;
    localparam int unsigned DEF_SIZE_CLASSES   = 32;
    localparam int unsigned DEF_ARENA_BLOCKS   = 16;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE  = 2'd1;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [SIZE_W-1:0] size_bytes;
        logic [UNIT_W-1:0] atom_unit;
    } t_in;

    typedef struct packed {
        logic [UNIT_W-1:0] alloc_unit;
        logic [1:0]        status;
        logic [UNIT_W-1:0] atoms_in_use;
    } t_out;

endpackage

`default_nettype wire

// ===== hdl/size_class_pool_allocator.sv =====
// result: registered as EXEC completes, or for an allocation popped from a free list as
// POP completes (class-head ram read, then link ram read); an output stall holds either
// state; one transaction in flight at a time, the next accepted only back in IDLE
// reset: synchronous, clears list flags, count and output valid, parks the arena position
// at its end; head and link rams hold garbage until written and need no clearing pass
// depends on scpa_pkg and scpa_ram
`default_nettype none

module size_class_pool_allocator
    import scpa_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES    = DEF_BLOCK_BYTES,
    parameter int unsigned MAX_ATOM_BYTES = DEF_MAX_ATOM_BYTES,
    parameter int unsigned SIZE_CLASSES   = DEF_SIZE_CLASSES,
    parameter int unsigned ARENA_BLOCKS   = DEF_ARENA_BLOCKS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int unsigned BLOCK_UNITS = BLOCK_BYTES / 8;
    localparam int unsigned CW     = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
    localparam int unsigned CUR_W  = $clog2(ARENA_BLOCKS + 1);
    localparam int unsigned USED_W = $clog2(BLOCK_UNITS + 1);
    localparam int unsigned SUM_W  = USED_W + 2;
    localparam int unsigned LAW    = $clog2(LINK_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    localparam logic [UNIT_W-1:0] COUNT_MAX = '1;

    logic [1:0]              r_state, n_state;
    logic [SIZE_CLASSES-1:0] r_nonempty, n_nonempty;
    logic [CUR_W-1:0]        r_cur, n_cur;
    logic [USED_W-1:0]       r_used, n_used;
    logic [UNIT_W-1:0]       r_count, n_count;
    logic                    r_out_valid, n_out_valid;
    t_out                    r_out, n_out;

    logic [1:0]         r_cmd;
    logic [UNIT_W-1:0]  r_atom;
    logic [UNITS_W-1:0] r_units;
    logic [CW-1:0]      r_cls;
    logic               r_ok;

    logic               in_accept;
    logic [SIZE_W:0]    in_round;
    logic [UNITS_W-1:0] in_units;
    logic [CW-1:0]      in_cls;
    logic               in_ok;

    logic              head_we;
    logic [UNIT_W-1:0] head_wdata;
    logic [UNIT_W-1:0] head_rdata;
    logic              link_we;
    logic [UNIT_W-1:0] link_wdata;
    logic              link_re;
    logic [UNIT_W-1:0] link_rdata;

    logic              can_finish;
    logic              cls_nonempty;
    logic              overflow;
    logic [CUR_W-1:0]  nb_blk;
    logic [USED_W-1:0] nb_used;
    logic              exhausted;
    logic [31:0]       bump_addr;
    logic [UNIT_W-1:0] count_inc;

    assign in_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    assign in_round = {1'b0, i_in_data.size_bytes} + (SIZE_W + 1)'(7);
    assign in_units = in_round[SIZE_W:3];
    assign in_cls   = CW'(in_units - UNITS_W'(1));
    assign in_ok    = (i_in_data.size_bytes != '0)
                   && (11'(i_in_data.size_bytes) <= 11'(MAX_ATOM_BYTES))
                   && (8'(in_units) <= 8'(SIZE_CLASSES));

    scpa_ram #(
        .WIDTH(UNIT_W),
        .DEPTH(SIZE_CLASSES)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (r_cls),
        .i_wdata (head_wdata),
        .i_re    (in_accept),
        .i_raddr (in_cls),
        .o_rdata (head_rdata)
    );

    scpa_ram #(
        .WIDTH(UNIT_W),
        .DEPTH(LINK_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_atom[LAW-1:0]),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (head_rdata[LAW-1:0]),
        .o_rdata (link_rdata)
    );

    // bump allocation in the current block, or the first free unit of the next one
    assign can_finish   = !r_out_valid || i_out_ready;
    assign cls_nonempty = r_nonempty[r_cls];
    assign overflow     = (SUM_W'(r_used) + SUM_W'(r_units)) > SUM_W'(BLOCK_UNITS);
    assign nb_blk  = !overflow ? r_cur
                   : ((r_cur >= CUR_W'(ARENA_BLOCKS)) ? '0 : r_cur + CUR_W'(1));
    assign nb_used = overflow ? USED_W'(1) : r_used;
    assign exhausted = (nb_blk >= CUR_W'(ARENA_BLOCKS))
                    || ((SUM_W'(nb_used) + SUM_W'(r_units)) > SUM_W'(BLOCK_UNITS));
    assign bump_addr = 32'(nb_blk) * 32'(BLOCK_UNITS) + 32'(nb_used);
    assign count_inc = (r_count < COUNT_MAX) ? r_count + UNIT_W'(1) : r_count;

    always_comb begin
        n_state     = r_state;
        n_nonempty  = r_nonempty;
        n_cur       = r_cur;
        n_used      = r_used;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        head_we     = 1'b0;
        head_wdata  = r_atom;
        link_we     = 1'b0;
        link_wdata  = '0;
        link_re     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (can_finish) begin
                    n_state          = ST_IDLE;
                    n_out_valid      = 1'b1;
                    n_out.alloc_unit = '0;
                    n_out.status     = STATUS_OK;
                    case (r_cmd)
                        CMD_ALLOC: begin
                            if (!r_ok) begin
                                n_out.status = STATUS_BAD_SIZE;
                            end else if (cls_nonempty) begin
                                n_state     = ST_POP;
                                n_out_valid = r_out_valid && !i_out_ready;
                                link_re     = 1'b1;
                            end else if (exhausted) begin
                                n_out.status = STATUS_EXHAUSTED;
                            end else begin
                                n_out.alloc_unit = bump_addr[UNIT_W-1:0];
                                n_cur   = nb_blk;
                                n_used  = USED_W'(SUM_W'(nb_used) + SUM_W'(r_units));
                                n_count = count_inc;
                            end
                        end
                        CMD_FREE: begin
                            if (!r_ok) begin
                                n_out.status = STATUS_BAD_SIZE;
                            end else if (r_count == '0) begin
                                n_out.status = STATUS_UNDERFLOW;
                            end else begin
                                link_we    = 1'b1;
                                link_wdata = cls_nonempty ? head_rdata : '0;
                                head_we    = 1'b1;
                                head_wdata = r_atom;
                                n_nonempty[r_cls] = 1'b1;
                                n_count = r_count - UNIT_W'(1);
                            end
                        end
                        CMD_RELEASE: begin
                            n_nonempty = '0;
                            n_cur      = CUR_W'(ARENA_BLOCKS);
                            n_used     = USED_W'(BLOCK_UNITS);
                            n_count    = '0;
                        end
                        default: begin
                            n_out.status = STATUS_OK;
                        end
                    endcase
                    n_out.atoms_in_use = n_count;
                end
            end
            ST_POP: begin
                if (can_finish) begin
                    n_state            = ST_IDLE;
                    head_we            = 1'b1;
                    head_wdata         = link_rdata;
                    n_nonempty[r_cls]  = (link_rdata != '0);
                    n_count            = count_inc;
                    n_out_valid        = 1'b1;
                    n_out.alloc_unit   = head_rdata;
                    n_out.status       = STATUS_OK;
                    n_out.atoms_in_use = count_inc;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nonempty  <= '0;
            r_cur       <= CUR_W'(ARENA_BLOCKS);
            r_used      <= USED_W'(BLOCK_UNITS);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nonempty  <= n_nonempty;
            r_cur       <= n_cur;
            r_used      <= n_used;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_accept) begin
            r_cmd   <= i_in_data.cmd;
            r_atom  <= i_in_data.atom_unit;
            r_units <= in_units;
            r_cls   <= in_cls;
            r_ok    <= in_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== hdl/scpa_ram.sv =====
// scpa_ram: generic simple dual-port ram, one write and one read port
// read data registered on read enable; no dependencies
`default_nettype none

module scpa_ram #(
    parameter int unsigned WIDTH = 14,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== tb/sv/pool_alloc_checker.sv =====
// pool_alloc_checker: watches both channels of the size-class pool allocator, keeps its own
// copy of the free lists and arena position, and compares every reply with the predicted one
// depends on scpa_pkg
module pool_alloc_checker
    import scpa_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES    = DEF_BLOCK_BYTES,
    parameter int unsigned MAX_ATOM_BYTES = DEF_MAX_ATOM_BYTES,
    parameter int unsigned SIZE_CLASSES   = DEF_SIZE_CLASSES,
    parameter int unsigned ARENA_BLOCKS   = DEF_ARENA_BLOCKS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_ready,
    input  wire t_in  i_in_data,
    input  wire logic i_out_valid,
    input  wire logic i_out_ready,
    input  wire t_out i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int unsigned BLOCK_UNITS = BLOCK_BYTES / 8;
    localparam int unsigned COUNT_MAX   = (1 << UNIT_W) - 1;
    localparam int          MAX_REPORTS = 100;

    logic [UNIT_W-1:0] head_of_class  [SIZE_CLASSES];
    logic              class_has_free [SIZE_CLASSES];
    logic [UNIT_W-1:0] next_free_link [LINK_DEPTH];
    int unsigned       arena_block;
    int unsigned       block_fill;
    int unsigned       live_count;
    t_out              owed_replies[$];
    int                fail_total = 0;
    int                replies_seen = 0;

    assign o_fail_count = fail_total;

    function automatic void clear_pool();
        for (int i = 0; i < SIZE_CLASSES; i++) begin
            class_has_free[i] = 1'b0;
            head_of_class[i]  = '0;
        end
        arena_block = ARENA_BLOCKS;
        block_fill  = BLOCK_UNITS;
        live_count  = 0;
    endfunction

    function automatic int class_index(logic [SIZE_W-1:0] nbytes);
        int unsigned k;
        if (nbytes == 0 || nbytes > MAX_ATOM_BYTES) return -1;
        k = ((int'(nbytes) + 7) >> 3) - 1;
        if (k >= SIZE_CLASSES) return -1;
        return int'(k);
    endfunction

    function automatic t_out pool_reply(t_in req);
        t_out              res;
        int                k;
        int unsigned       need;
        int unsigned       blk;
        int unsigned       used;
        logic [UNIT_W-1:0] addr;
        logic [UNIT_W-1:0] link;
        res = '0;
        case (req.cmd)
            CMD_ALLOC: begin
                k = class_index(req.size_bytes);
                if (k < 0) begin
                    res.status = STATUS_BAD_SIZE;
                end else if (class_has_free[k]) begin
                    addr = head_of_class[k];
                    link = next_free_link[addr];
                    head_of_class[k]  = link;
                    class_has_free[k] = (link != '0);
                    res.alloc_unit    = addr;
                    if (live_count < COUNT_MAX) live_count++;
                end else begin
                    need = k + 1;
                    blk  = arena_block;
                    used = block_fill;
                    if (used + need > BLOCK_UNITS) begin
                        blk  = (arena_block >= ARENA_BLOCKS) ? 0 : arena_block + 1;
                        used = 1;
                    end
                    if (blk >= ARENA_BLOCKS || used + need > BLOCK_UNITS) begin
                        res.status = STATUS_EXHAUSTED;
                    end else begin
                        res.alloc_unit = UNIT_W'(blk * BLOCK_UNITS + used);
                        arena_block    = blk;
                        block_fill     = used + need;
                        if (live_count < COUNT_MAX) live_count++;
                    end
                end
            end
            CMD_FREE: begin
                k = class_index(req.size_bytes);
                if (k < 0) begin
                    res.status = STATUS_BAD_SIZE;
                end else if (live_count == 0) begin
                    res.status = STATUS_UNDERFLOW;
                end else begin
                    next_free_link[req.atom_unit] = class_has_free[k] ? head_of_class[k] : '0;
                    head_of_class[k]  = req.atom_unit;
                    class_has_free[k] = 1'b1;
                    live_count--;
                end
            end
            CMD_RELEASE: clear_pool();
            default: ;
        endcase
        res.atoms_in_use = UNIT_W'(live_count);
        return res;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (fail_total < MAX_REPORTS)
            $display("mismatch on reply %0d, %s: got %0d, expected %0d",
                     replies_seen, what, got, want);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            clear_pool();
            owed_replies.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                owed_replies.push_back(pool_reply(i_in_data));
            if (i_out_valid && i_out_ready) begin
                replies_seen++;
                if (owed_replies.size() == 0) begin
                    flag_mismatch("reply with no open transaction", 0, 0);
                end else begin
                    want = owed_replies.pop_front();
                    if (i_out_data.alloc_unit !== want.alloc_unit)
                        flag_mismatch("alloc_unit", i_out_data.alloc_unit, want.alloc_unit);
                    if (i_out_data.status !== want.status)
                        flag_mismatch("status", i_out_data.status, want.status);
                    if (i_out_data.atoms_in_use !== want.atoms_in_use)
                        flag_mismatch("atoms_in_use", i_out_data.atoms_in_use,
                                      want.atoms_in_use);
                end
            end
        end
        o_pending <= owed_replies.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// tb: drives the size-class pool allocator with directed corner cases, free-list churn and
// one arena fill past exhaustion, under random sender bursts and receiver stalls
// depends on scpa_pkg, size_class_pool_allocator and pool_alloc_checker
module tb;
    import scpa_pkg::*;

    localparam logic [1:0]  CMD_UNKNOWN    = 2'd3;
    localparam int          IN_W           = $bits(t_in);
    localparam int          RANDOM_ITEMS   = 1050;
    localparam int          FILL_START     = 300;
    localparam int          FILL_ITEMS     = 520;
    localparam int          HOLD_AT        = 60;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 12;

    typedef struct packed {
        logic [UNIT_W-1:0] addr;
        logic [SIZE_W-1:0] nbytes;
    } t_live;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;
    int   fail_count;
    int   pending;

    t_in   open_reqs[$];
    t_live live_atoms[$];
    int    accepted_in = 0;
    int    idle_cycles = 0;
    int    burst_left  = 0;

    size_class_pool_allocator dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    pool_alloc_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // live atom pool for well-formed frees
    always @(posedge clk) begin
        t_in   req;
        t_live atom;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                open_reqs.push_back(in_data);
                accepted_in <= accepted_in + 1;
            end
            if (out_valid && out_ready && open_reqs.size() > 0) begin
                req = open_reqs.pop_front();
                if (req.cmd == CMD_RELEASE) begin
                    live_atoms.delete();
                end else if (req.cmd == CMD_ALLOC && out_data.status == STATUS_OK) begin
                    atom.addr   = out_data.alloc_unit;
                    atom.nbytes = req.size_bytes;
                    live_atoms.push_back(atom);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        int mode;
        int run_len;
        bit hold_taken;
        out_ready = 1'b0;
        hold_taken = 1'b0;
        wait (rst_n);
        forever begin
            if (!hold_taken && accepted_in >= HOLD_AT) begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(4, 40);
            repeat (run_len) begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic t_in make_op(logic [1:0] cmd, int nbytes, int unit);
        t_in item;
        item.cmd        = cmd;
        item.size_bytes = SIZE_W'(nbytes);
        item.atom_unit  = UNIT_W'(unit);
        return item;
    endfunction

    function automatic t_in churn_op();
        t_in              item;
        logic [IN_W-1:0] raw;
        int               pick;
        int               roll;
        item = make_op(CMD_ALLOC,
                       $urandom_range(1, ($urandom_range(0, 3) == 0) ? 256 : 48), $urandom);
        roll = $urandom_range(0, 99);
        if (roll < 40 && live_atoms.size() > 0) begin
            pick = $urandom_range(0, live_atoms.size() - 1);
            item = make_op(CMD_FREE, live_atoms[pick].nbytes, live_atoms[pick].addr);
            live_atoms.delete(pick);
        end else if (roll >= 85) begin
            raw  = IN_W'($urandom);
            item = raw;
        end
        return item;
    endfunction

    task automatic offer(t_in item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial begin : stimulus
        int  random_sent;
        t_in item;
        random_sent = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // underflow, bad sizes, class edges, lifo order, unit 0 in a list, release
        offer(make_op(CMD_FREE, 8, 5));
        offer(make_op(CMD_ALLOC, 0, 0));
        offer(make_op(CMD_ALLOC, 257, 0));
        offer(make_op(CMD_ALLOC, 511, 0));
        offer(make_op(CMD_FREE, 0, 7));
        offer(make_op(CMD_ALLOC, 1, 0));
        offer(make_op(CMD_ALLOC, 8, 0));
        offer(make_op(CMD_ALLOC, 9, 0));
        offer(make_op(CMD_ALLOC, 256, 0));
        offer(make_op(CMD_ALLOC, 249, 0));
        offer(make_op(CMD_UNKNOWN, 511, 16383));
        offer(make_op(CMD_FREE, 300, 3));
        offer(make_op(CMD_FREE, 1, 1));
        offer(make_op(CMD_FREE, 8, 2));
        offer(make_op(CMD_ALLOC, 5, 0));
        offer(make_op(CMD_ALLOC, 8, 0));
        offer(make_op(CMD_ALLOC, 7, 0));
        offer(make_op(CMD_FREE, 16, 0));
        offer(make_op(CMD_FREE, 16, 16383));
        offer(make_op(CMD_ALLOC, 16, 0));
        offer(make_op(CMD_ALLOC, 16, 0));
        offer(make_op(CMD_ALLOC, 16, 0));
        offer(make_op(CMD_RELEASE, 0, 0));
        offer(make_op(CMD_ALLOC, 256, 16383));
        offer(make_op(CMD_RELEASE, 511, 16383));

        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= FILL_START && random_sent < FILL_START + FILL_ITEMS) begin
                // FILL_ITEMS large atoms, more than the arena holds, to run it past exhaustion
                repeat (FILL_ITEMS) begin
                    offer(make_op(CMD_ALLOC, $urandom_range(249, 256), $urandom));
                    random_sent++;
                end
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    offer(make_op(CMD_RELEASE, $urandom, $urandom));
                    random_sent++;
                end
                repeat ($urandom_range(20, 60)) begin
                    item = churn_op();
                    offer(item);
                    if (item.cmd != CMD_UNKNOWN) random_sent++;
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("ran %0d transactions: corner cases, free-list churn, arena fill past exhaustion",
                 accepted_in);
        $display("with sender bursts, receiver stalls and one long receiver hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
